FILE: sv/lgs_pkg.sv
// shared types and constants for the life generation step block
`default_nettype none

package lgs_pkg;

  localparam int GRID_SIZE_DEF = 32;
  localparam int ROW_W         = 32;
  localparam int IDX_W         = 5;
  localparam int GEN_W         = 32;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_ADVANCE = 2'd1,
    ACT_READ    = 2'd2
  } action_t;

  // per-cycle commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // latch the input transaction
    logic load_wr;   // write the latched row
    logic rd_ri;     // read the addressed row
    logic rd_cap;    // capture read data as the result row
    logic rd_sweep;  // sweep read at the address set by the step count
    logic sw_top;    // old last row arrives, start of advance
    logic sw_row0;   // old row 0 arrives
    logic sw_mid;    // next row arrives, compute and write one row
    logic sw_last;   // compute and write the last row, finish advance
  } lgs_cmd_t;

endpackage

`default_nettype wire

FILE: sv/life_generation_step.sv
// top level of the life generation step block
`default_nettype none

// Conway life grid of GRID_SIZE x GRID_SIZE cells under the b3/s23 rule.
// A transaction is taken at a rising edge with start high and busy low;
// busy stays high while it is worked on. Every transaction gives exactly
// one result, shown for one cycle with out_valid high; the receiver cannot
// stall it, so it must take the result in that cycle. A new transaction may
// be started in the same cycle that a result is shown. The advance time is
// set by the single read port of the grid memory: the sweep reads the old
// last row, then every row once into a three-row window, writing each new
// row back a row behind the reads. Rows 32 and up of a larger grid cannot
// be addressed by row_index; columns 32 and up cannot be loaded and do not
// show on out_row_out. After reset the grid reads all dead at once through
// per-row valid bits, with no clearing pass. edge_wrap is written through
// the cfg_ channel, always ready, and may only change while the block is
// idle.

module life_generation_step #(
  parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // command transaction
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_action,
  input  logic [lgs_pkg::IDX_W-1:0] in_row_index,
  input  logic [lgs_pkg::ROW_W-1:0] in_row_bits,
  // result transaction
  output logic                      out_valid,
  output logic [lgs_pkg::ROW_W-1:0] out_row_out,
  output logic                      out_stable,
  output logic                      out_all_dead,
  output logic [lgs_pkg::GEN_W-1:0] out_generation,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_edge_wrap
);

  import lgs_pkg::*;

  localparam int CW = $clog2(GRID_SIZE + 3);

  lgs_cmd_t      cmd;
  logic [CW-1:0] sweep_k;

  // config writes are taken on any cycle
  assign cfg_ready = 1'b1;

  // sequencing: accept, load write, row read, and the advance sweep
  lgs_ctrl #(
    .GRID_SIZE (GRID_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sweep_k   (sweep_k)
  );

  // grid storage, rule window and result registers
  lgs_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sweep_k        (sweep_k),
    .in_row_index   (in_row_index),
    .in_row_bits    (in_row_bits),
    .cfg_valid      (cfg_valid & cfg_ready),
    .cfg_edge_wrap  (cfg_edge_wrap),
    .out_row_out    (out_row_out),
    .out_stable     (out_stable),
    .out_all_dead   (out_all_dead),
    .out_generation (out_generation)
  );

endmodule

`default_nettype wire

FILE: sv/lgs_row_rule.sv
// b3/s23 rule applied to one row from a three-row window
`default_nettype none

module lgs_row_rule #(
  parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
  input  logic [GRID_SIZE-1:0] up,
  input  logic [GRID_SIZE-1:0] mid,
  input  logic [GRID_SIZE-1:0] dn,
  input  logic                 wrap,
  output logic [GRID_SIZE-1:0] nrow,
  output logic                 changed
);

  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
    localparam int  CL    = (c == 0) ? GRID_SIZE - 1 : c - 1;
    localparam int  CR    = (c == GRID_SIZE - 1) ? 0 : c + 1;
    localparam bit  LEDGE = (c == 0);
    localparam bit  REDGE = (c == GRID_SIZE - 1);
    logic       el;
    logic       er;
    logic [7:0] nb;
    logic [3:0] cnt;

    // horizontal neighbors past the edge count only when wrapping
    assign el = LEDGE ? wrap : 1'b1;
    assign er = REDGE ? wrap : 1'b1;
    assign nb = {up[CL] & el, up[c], up[CR] & er,
                 mid[CL] & el, mid[CR] & er,
                 dn[CL] & el, dn[c], dn[CR] & er};
    assign cnt = 4'(nb[0]) + 4'(nb[1]) + 4'(nb[2]) + 4'(nb[3]) +
                 4'(nb[4]) + 4'(nb[5]) + 4'(nb[6]) + 4'(nb[7]);
    assign nrow[c] = (cnt == 4'd3) | (mid[c] & (cnt == 4'd2));
  end

  assign changed = |(nrow ^ mid);

endmodule

`default_nettype wire

FILE: sv/lgs_ctrl.sv
// controller state machine for the life generation step block
`default_nettype none

module lgs_ctrl #(
  parameter  int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF,
  localparam int CW        = $clog2(GRID_SIZE + 3)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_action,
  output logic             busy,
  output logic             out_valid,
  output lgs_pkg::lgs_cmd_t cmd,
  output logic [CW-1:0]    sweep_k
);

  import lgs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_READ,
    S_RDATA,
    S_SWEEP
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  action_t       act;

  assign act = action_t'(in_action);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          k_nxt      = '0;
          case (act)
            ACT_LOAD:    state_nxt = S_LOAD;
            ACT_ADVANCE: state_nxt = S_SWEEP;
            default:     state_nxt = S_READ;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_wr   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_READ: begin
        cmd.rd_ri = 1'b1;
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        cmd.rd_cap    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SWEEP: begin
        cmd.rd_sweep = (k_r <= CW'(GRID_SIZE));
        cmd.sw_top   = (k_r == CW'(1));
        cmd.sw_row0  = (k_r == CW'(2));
        cmd.sw_mid   = (k_r >= CW'(3)) && (k_r <= CW'(GRID_SIZE + 1));
        cmd.sw_last  = (k_r == CW'(GRID_SIZE + 2));
        k_nxt        = k_r + CW'(1);
        if (k_r == CW'(GRID_SIZE + 2)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign sweep_k   = k_r;

endmodule

`default_nettype wire

FILE: sv/lgs_datapath.sv
// grid memory, three-row window, flags and counters
`default_nettype none

module lgs_datapath #(
  parameter  int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF,
  localparam int CW        = $clog2(GRID_SIZE + 3)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lgs_pkg::lgs_cmd_t           cmd,
  input  logic [CW-1:0]               sweep_k,
  input  logic [lgs_pkg::IDX_W-1:0]   in_row_index,
  input  logic [lgs_pkg::ROW_W-1:0]   in_row_bits,
  input  logic                        cfg_valid,
  input  logic                        cfg_edge_wrap,
  output logic [lgs_pkg::ROW_W-1:0]   out_row_out,
  output logic                        out_stable,
  output logic                        out_all_dead,
  output logic [lgs_pkg::GEN_W-1:0]   out_generation
);

  import lgs_pkg::*;

  localparam int AW = $clog2(GRID_SIZE);

  logic [GRID_SIZE-1:0] mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] vld_r;
  logic [GRID_SIZE-1:0] nz_r;
  logic [GRID_SIZE-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic [GRID_SIZE-1:0] prev_r;
  logic [GRID_SIZE-1:0] cur_r;
  logic [GRID_SIZE-1:0] row0_r;
  logic                 chg_r;
  logic                 stable_r;
  logic [GEN_W-1:0]     gen_r;
  logic                 wrap_r;
  logic [IDX_W-1:0]     ri_r;
  logic [ROW_W-1:0]     bits_r;
  logic [ROW_W-1:0]     row_out_r;

  logic                 ri_ok;
  logic [AW-1:0]        ri_addr;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [GRID_SIZE-1:0] rd_row;
  logic [GRID_SIZE-1:0] load_row;
  logic [GRID_SIZE-1:0] dn_row;
  logic [GRID_SIZE-1:0] nrow;
  logic                 changed;
  logic                 we;
  logic [AW-1:0]        wa;
  logic [GRID_SIZE-1:0] wd;
  logic                 sw_wr;
  logic [AW-1:0]        sw_addr;

  assign ri_ok    = (32'(ri_r) < 32'(GRID_SIZE));
  assign ri_addr  = AW'(ri_r);
  assign load_row = GRID_SIZE'(bits_r);
  // a row never written since reset reads as all dead
  assign rd_row   = rd_vld_r ? rd_data_r : '0;

  // sweep order: old last row first, then rows 0 up to the last
  assign rd_en   = cmd.rd_ri | cmd.rd_sweep;
  assign rd_addr = cmd.rd_ri ? ri_addr :
                   (sweep_k == '0) ? AW'(GRID_SIZE - 1) : AW'(sweep_k - CW'(1));

  assign dn_row  = cmd.sw_last ? (wrap_r ? row0_r : '0) : rd_row;
  assign sw_wr   = cmd.sw_mid | cmd.sw_last;
  assign sw_addr = cmd.sw_last ? AW'(GRID_SIZE - 1) : AW'(sweep_k - CW'(3));

  lgs_row_rule #(
    .GRID_SIZE (GRID_SIZE)
  ) u_rule (
    .up      (prev_r),
    .mid     (cur_r),
    .dn      (dn_row),
    .wrap    (wrap_r),
    .nrow    (nrow),
    .changed (changed)
  );

  always_comb begin
    we = 1'b0;
    wa = sw_addr;
    wd = nrow;
    if (cmd.load_wr) begin
      we = ri_ok;
      wa = ri_addr;
      wd = load_row;
    end else if (sw_wr) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      nz_r     <= '0;
      stable_r <= 1'b1;
      gen_r    <= '0;
      wrap_r   <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wa] <= 1'b1;
        nz_r[wa]  <= |wd;
      end
      if (cmd.sw_last) begin
        stable_r <= !(chg_r | changed);
        gen_r    <= gen_r + GEN_W'(1);
      end
      if (cfg_valid) begin
        wrap_r <= cfg_edge_wrap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ri_r   <= in_row_index;
      bits_r <= in_row_bits;
    end
    if (cmd.sw_top) begin
      prev_r <= wrap_r ? rd_row : '0;
      chg_r  <= 1'b0;
    end
    if (cmd.sw_row0) begin
      cur_r  <= rd_row;
      row0_r <= rd_row;
    end
    if (cmd.sw_mid) begin
      prev_r <= cur_r;
      cur_r  <= rd_row;
      chg_r  <= chg_r | changed;
    end
    if (cmd.load_wr) begin
      row_out_r <= ri_ok ? ROW_W'(load_row) : '0;
    end else if (cmd.rd_cap) begin
      row_out_r <= ri_ok ? ROW_W'(rd_row) : '0;
    end else if (cmd.sw_top) begin
      row_out_r <= '0;
    end else if (sw_wr && ri_ok && (sw_addr == ri_addr)) begin
      row_out_r <= ROW_W'(nrow);
    end
  end

  assign out_row_out    = row_out_r;
  assign out_stable     = stable_r;
  assign out_all_dead   = ~|nz_r;
  assign out_generation = gen_r;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for the life generation step block
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lgs_pkg::*;

  localparam int GS = GRID_SIZE_DEF;
  // b3/s23: a live cell keeps living on 2 or 3 neighbours, a dead one is born on 3
  localparam int SURVIVE_MIN = 2;
  localparam int BIRTH_COUNT = 3;
  // the action encoding leaves one code spare; the block answers it like a read
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int ITEM_TARGET = 1200;
  // quiet cycles allowed: longest sender gap plus an advance plus the final drain
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [GS-1:0] row_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_out;
    logic             stable;
    logic             all_dead;
    logic [GEN_W-1:0] generation;
  } life_result_t;

  // keeps its own copy of the grid, works out the answer of every accepted
  // command and holds those answers in order until the block shows them
  class life_tracker;
    row_t         cells [GS];
    bit           steady;
    bit [GEN_W-1:0] gen_count;
    bit           wrap_edges;
    life_result_t expected_results [$];
    int           errors;

    function new();
      foreach (cells[k]) cells[k] = '0;
      steady = 1'b1;
      gen_count = '0;
      wrap_edges = 1'b0;
      errors = 0;
    endfunction

    function void set_wrap(bit v);
      wrap_edges = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // outside cells are dead, or folded back onto the grid when edges wrap
    function bit cell_at(int r, int c);
      if (r < 0 || r >= GS || c < 0 || c >= GS) begin
        if (!wrap_edges) return 1'b0;
        r = (r + GS) % GS;
        c = (c + GS) % GS;
      end
      return cells[r][c];
    endfunction

    // every new cell is taken from the old grid, then the grid is swapped
    function void next_generation();
      row_t fresh [GS];
      bit   changed;
      bit   alive;
      bit   nxt;
      int   n;
      changed = 1'b0;
      for (int r = 0; r < GS; r++) begin
        for (int c = 0; c < GS; c++) begin
          n = 0;
          alive = cell_at(r, c);
          for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
              if (dr != 0 || dc != 0) n += cell_at(r + dr, c + dc);
          nxt = alive ? (n == SURVIVE_MIN || n == BIRTH_COUNT) : (n == BIRTH_COUNT);
          if (nxt != alive) changed = 1'b1;
          fresh[r][c] = nxt;
        end
      end
      cells = fresh;
      steady = !changed;
      gen_count = gen_count + 1'b1;
    endfunction

    function void note_command(logic [1:0] act, logic [IDX_W-1:0] ri,
                               logic [ROW_W-1:0] bits);
      life_result_t want;
      bit any_alive;
      case (act)
        ACT_LOAD:    if (ri < GS) cells[ri] = row_t'(bits);
        ACT_ADVANCE: next_generation();
        default: ;
      endcase
      any_alive = 1'b0;
      foreach (cells[k]) if (cells[k] != '0) any_alive = 1'b1;
      want.row_out    = (ri < GS) ? ROW_W'(cells[ri]) : '0;
      want.stable     = steady;
      want.all_dead   = !any_alive;
      want.generation = gen_count;
      expected_results.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(life_result_t got);
      life_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result with no command waiting, row_out %h", got.row_out));
        return;
      end
      want = expected_results.pop_front();
      if (got.row_out !== want.row_out)
        report($sformatf("row_out %h, want %h", got.row_out, want.row_out));
      if (got.stable !== want.stable)
        report($sformatf("stable %b, want %b", got.stable, want.stable));
      if (got.all_dead !== want.all_dead)
        report($sformatf("all_dead %b, want %b", got.all_dead, want.all_dead));
      if (got.generation !== want.generation)
        report($sformatf("generation %0d, want %0d", got.generation, want.generation));
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_action;
  logic [IDX_W-1:0] in_row_index;
  logic [ROW_W-1:0] in_row_bits;
  logic             out_valid;
  logic [ROW_W-1:0] out_row_out;
  logic             out_stable;
  logic             out_all_dead;
  logic [GEN_W-1:0] out_generation;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_edge_wrap;

  life_tracker tracker;
  int          burst_left;
  int          items_sent;
  int          quiet_cycles;

  life_generation_step #(.GRID_SIZE(GS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_row_index   (in_row_index),
    .in_row_bits    (in_row_bits),
    .out_valid      (out_valid),
    .out_row_out    (out_row_out),
    .out_stable     (out_stable),
    .out_all_dead   (out_all_dead),
    .out_generation (out_generation),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_edge_wrap  (cfg_edge_wrap)
  );

  always #5 clk = ~clk;

  // monitor: everything is sampled at the rising edge, before any driver
  // update of that edge lands, so command, result and config transactions
  // are seen exactly as the block sees them
  always @(posedge clk) begin
    if (rst_n) begin
      // note the new command first so a result shown in its acceptance
      // cycle would still find its expectation
      if (start && !busy) tracker.note_command(in_action, in_row_index, in_row_bits);
      if (out_valid)
        tracker.check_result('{out_row_out, out_stable, out_all_dead, out_generation});
      if (cfg_valid && cfg_ready) tracker.set_wrap(cfg_edge_wrap);
      // watchdog on cycles where no transaction of any kind moves
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // sparse rows dominate so that grids settle, die out or oscillate often
  function automatic logic [ROW_W-1:0] seed_row();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      4, 5:    return $urandom & $urandom;
      6:       return $urandom & $urandom & $urandom;
      default: return ROW_W'(32'h7) << $urandom_range(0, ROW_W - 1);
    endcase
  endfunction

  // drive one command and hold it until taken; the sender runs in bursts,
  // and between bursts start drops for a random gap, sometimes longer than
  // an advance so gaps land on every phase of the sweep
  task automatic send_item(input logic [1:0] act, input int row,
                           input logic [ROW_W-1:0] bits);
    start        <= 1'b1;
    in_action    <= act;
    in_row_index <= IDX_W'(row);
    in_row_bits  <= bits;
    do @(posedge clk); while (busy);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(0, 6);
      repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 5)) @(posedge clk);
    end
  endtask

  // every command gives a result, so the block is idle once none is awaited
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // the edge mode may only change while the block is idle
  task automatic write_wrap(input bit v);
    drain();
    cfg_valid     <= 1'b1;
    cfg_edge_wrap <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int pick;
    tracker       = new();
    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_action     = ACT_LOAD;
    in_row_index  = '0;
    in_row_bits   = '0;
    cfg_valid     = 1'b0;
    cfg_edge_wrap = 1'b0;
    burst_left    = 0;
    items_sent    = 0;
    quiet_cycles  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: empty grid, stable, generation zero; edges dead
    send_item(ACT_READ, 0, '0);
    // spare action code changes nothing and answers like a read
    send_item(ACT_SPARE, 31, '1);
    // advancing an empty grid keeps it stable
    send_item(ACT_ADVANCE, 0, '0);
    // full top and bottom rows against dead edges
    send_item(ACT_LOAD, 0, '1);
    send_item(ACT_LOAD, 31, '1);
    send_item(ACT_ADVANCE, 31, '0);
    send_item(ACT_READ, 1, '0);
    send_item(ACT_READ, 30, '0);

    // toroidal edges: a blinker lying across both the row and column seams
    write_wrap(1'b1);
    send_item(ACT_LOAD, 0, '0);
    send_item(ACT_LOAD, 1, '0);
    send_item(ACT_LOAD, 30, '0);
    send_item(ACT_LOAD, 31, '0);
    send_item(ACT_LOAD, 31, 32'h8000_0003);
    send_item(ACT_ADVANCE, 0, '0);
    send_item(ACT_READ, 30, '0);
    send_item(ACT_ADVANCE, 31, '0);

    // a block still life after clearing: advance must report stable
    send_item(ACT_LOAD, 30, '0);
    send_item(ACT_LOAD, 31, '0);
    send_item(ACT_LOAD, 0, '0);
    send_item(ACT_LOAD, 5, 32'h30);
    send_item(ACT_LOAD, 6, 32'h30);
    send_item(ACT_ADVANCE, 5, '0);

    // random episodes: seed some rows, then let the grid evolve with reads
    // and a little noise; sometimes wipe the grid first so it can die out
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) write_wrap($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0)
        for (int r = 0; r < 32; r++) send_item(ACT_LOAD, r, '0);
      repeat ($urandom_range(2, 12)) send_item(ACT_LOAD, $urandom_range(0, 31), seed_row());
      repeat ($urandom_range(4, 16)) begin
        pick = $urandom_range(0, 19);
        if (pick < 12)      send_item(ACT_ADVANCE, $urandom_range(0, 31), $urandom);
        else if (pick < 17) send_item(ACT_READ, $urandom_range(0, 31), $urandom);
        else if (pick < 18) send_item(ACT_SPARE, $urandom_range(0, 31), $urandom);
        else                send_item(ACT_LOAD, $urandom_range(0, 31), seed_row());
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (tracker.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
sv/lgs_pkg.sv
sv/lgs_row_rule.sv
sv/lgs_ctrl.sv
sv/lgs_datapath.sv
sv/life_generation_step.sv
tb/tb_top.sv
